/* sv/ipv4rx_pkg.sv */
// Shared types, codes and a helper function for the IPv4 receive header checker.
package ipv4rx_pkg;

	localparam logic [2:0] VERDICT_DELIVER   = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_VERSION   = 3'd2;
	localparam logic [2:0] VERDICT_CHECKSUM  = 3'd3;
	localparam logic [2:0] VERDICT_DEST      = 3'd4;
	localparam logic [2:0] VERDICT_TRUNCATED = 3'd5;
	localparam logic [2:0] VERDICT_PROTO     = 3'd6;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [3:0]  IP_VERSION     = 4'd4;
	localparam logic [16:0] MIN_HEADER_LEN = 17'd20;

	typedef enum logic [3:0] {
		FLD_NONE,
		FLD_VER_IHL,
		FLD_LEN_HI,
		FLD_LEN_LO,
		FLD_PROTO,
		FLD_CSUM_HI,
		FLD_CSUM_LO,
		FLD_SRC,
		FLD_DST
	} field_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        last_byte;
		field_t      field;
		logic [1:0]  lane;
		logic        in_sum;
		logic [15:0] index;
	} rx_entry_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

/* sv/ipv4_receive_header_checker.sv */
// IPv4 receive header checker: one byte per cycle in while in_stall is low, one result per byte out.
// Each byte is registered into the queue and then into the back end's output register before its result is presented.
// Throughput: one byte per clock while out_stall is low, limited by the back end's single output register.
// The queue between front and back end absorbs output stalls up to QueueDepth bytes.
// Reset clears the byte position, all captured header state and local_ip to zero.
module ipv4_receive_header_checker import ipv4rx_pkg::*; #(
	parameter int QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        packet_end,
	output logic [2:0]  verdict,
	output logic [7:0]  protocol,
	output logic [31:0] source_addr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] local_ip
);

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_not_empty;
	rx_entry_t   q_entry;
	rx_entry_t   q_head;
	logic [31:0] local_ip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			local_ip_q <= local_ip;
		end
	end

	ipv4rx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	ipv4rx_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	ipv4rx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.local_ip_q    (local_ip_q),
		.q_not_empty   (q_not_empty),
		.head          (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.packet_end    (packet_end),
		.verdict       (verdict),
		.protocol      (protocol),
		.source_addr   (source_addr)
	);

endmodule

/* sv/ipv4rx_front.sv */
// Front end: accepts bytes, tracks the byte position and classifies each byte.
module ipv4rx_front import ipv4rx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [7:0] rx_byte,
	input  logic      last_byte,
	input  logic      q_full,
	output logic      q_push,
	output rx_entry_t q_entry
);

	logic [15:0] byte_index_q;
	field_t      field;

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	always_comb begin
		field = FLD_NONE;
		if (byte_index_q == 16'd0) begin
			field = FLD_VER_IHL;
		end else if (byte_index_q == 16'd2) begin
			field = FLD_LEN_HI;
		end else if (byte_index_q == 16'd3) begin
			field = FLD_LEN_LO;
		end else if (byte_index_q == 16'd9) begin
			field = FLD_PROTO;
		end else if (byte_index_q == 16'd10) begin
			field = FLD_CSUM_HI;
		end else if (byte_index_q == 16'd11) begin
			field = FLD_CSUM_LO;
		end else if (byte_index_q >= 16'd12 && byte_index_q <= 16'd15) begin
			field = FLD_SRC;
		end else if (byte_index_q >= 16'd16 && byte_index_q <= 16'd19) begin
			field = FLD_DST;
		end
	end

	always_comb begin
		q_entry.rx_byte   = rx_byte;
		q_entry.last_byte = last_byte;
		q_entry.field     = field;
		q_entry.lane      = byte_index_q[1:0];
		q_entry.in_sum    = byte_index_q < 16'd20;
		q_entry.index     = byte_index_q;
	end

	// The position saturates so that very long buffers still count as 65536 bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
		end else if (q_push) begin
			if (last_byte) begin
				byte_index_q <= '0;
			end else if (byte_index_q != 16'hFFFF) begin
				byte_index_q <= byte_index_q + 16'd1;
			end
		end
	end

endmodule

/* sv/ipv4rx_queue.sv */
// Short register queue between the front end and the back end.
module ipv4rx_queue import ipv4rx_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rx_entry_t push_entry,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output rx_entry_t head
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	rx_entry_t         entries_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = count_q == CntW'(Depth);
	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* sv/ipv4rx_back.sv */
// Back end: captures header fields, folds the checksum and produces results.
module ipv4rx_back import ipv4rx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] local_ip_q,
	input  logic        q_not_empty,
	input  rx_entry_t   head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        packet_end,
	output logic [2:0]  verdict,
	output logic [7:0]  protocol,
	output logic [31:0] source_addr
);

	logic [3:0]  header_words_q, header_words_d;
	logic [3:0]  version_q, version_d;
	logic [15:0] total_length_q, total_length_d;
	logic [7:0]  protocol_q, protocol_d;
	logic [31:0] source_q, source_d;
	logic [31:0] dest_q, dest_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  high_q, high_d;
	logic [15:0] rsum_q, rsum_d;

	logic        out_valid_q;
	logic [7:0]  payload_byte_q;
	logic        payload_valid_q;
	logic        packet_end_q;
	logic [2:0]  verdict_q;
	logic [7:0]  protocol_out_q;
	logic [31:0] source_out_q;

	logic [7:0]  sum_byte;
	logic [16:0] count;
	logic        is_payload;
	logic [2:0]  verdict_d;

	assign q_pop = q_not_empty & (~out_valid_q | ~out_stall);

	always_comb begin
		header_words_d = header_words_q;
		version_d      = version_q;
		total_length_d = total_length_q;
		protocol_d     = protocol_q;
		source_d       = source_q;
		dest_d         = dest_q;
		rsum_d         = rsum_q;
		sum_d          = sum_q;
		high_d         = high_q;

		unique case (head.field)
			FLD_VER_IHL: begin
				version_d      = head.rx_byte[7:4];
				header_words_d = head.rx_byte[3:0];
			end
			FLD_LEN_HI:  total_length_d[15:8] = head.rx_byte;
			FLD_LEN_LO:  total_length_d[7:0]  = head.rx_byte;
			FLD_PROTO:   protocol_d = head.rx_byte;
			FLD_CSUM_HI: rsum_d[15:8] = head.rx_byte;
			FLD_CSUM_LO: rsum_d[7:0]  = head.rx_byte;
			FLD_SRC: begin
				unique case (head.lane)
					2'd0: source_d[31:24] = head.rx_byte;
					2'd1: source_d[23:16] = head.rx_byte;
					2'd2: source_d[15:8]  = head.rx_byte;
					default: source_d[7:0] = head.rx_byte;
				endcase
			end
			FLD_DST: begin
				unique case (head.lane)
					2'd0: dest_d[31:24] = head.rx_byte;
					2'd1: dest_d[23:16] = head.rx_byte;
					2'd2: dest_d[15:8]  = head.rx_byte;
					default: dest_d[7:0] = head.rx_byte;
				endcase
			end
			default: ;
		endcase

		// The checksum field itself is summed as zero.
		sum_byte = (head.field == FLD_CSUM_HI || head.field == FLD_CSUM_LO) ? 8'd0 : head.rx_byte;
		if (head.in_sum) begin
			if (!head.index[0]) begin
				high_d = sum_byte;
			end else begin
				sum_d = ones_add(sum_q, {high_q, sum_byte});
			end
		end
	end

	always_comb begin
		count      = {1'b0, head.index} + 17'd1;
		is_payload = head.index >= 16'd4
			&& head.index >= {10'd0, header_words_d, 2'b00}
			&& head.index < total_length_d;

		verdict_d = VERDICT_DELIVER;
		if (head.last_byte) begin
			if (count < MIN_HEADER_LEN) begin
				verdict_d = VERDICT_SHORT;
			end else if (version_d != IP_VERSION) begin
				verdict_d = VERDICT_VERSION;
			end else if (~sum_d != rsum_d) begin
				verdict_d = VERDICT_CHECKSUM;
			end else if (dest_d != local_ip_q) begin
				verdict_d = VERDICT_DEST;
			end else if ({1'b0, total_length_d} > count) begin
				verdict_d = VERDICT_TRUNCATED;
			end else if (protocol_d != PROTO_ICMP && protocol_d != PROTO_TCP
				&& protocol_d != PROTO_UDP) begin
				verdict_d = VERDICT_PROTO;
			end
		end
	end

	// Packet state returns to zero after the last byte so the next packet starts clean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_words_q <= '0;
			version_q      <= '0;
			total_length_q <= '0;
			protocol_q     <= '0;
			source_q       <= '0;
			dest_q         <= '0;
			sum_q          <= '0;
			high_q         <= '0;
			rsum_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				if (head.last_byte) begin
					header_words_q <= '0;
					version_q      <= '0;
					total_length_q <= '0;
					protocol_q     <= '0;
					source_q       <= '0;
					dest_q         <= '0;
					sum_q          <= '0;
					high_q         <= '0;
					rsum_q         <= '0;
				end else begin
					header_words_q <= header_words_d;
					version_q      <= version_d;
					total_length_q <= total_length_d;
					protocol_q     <= protocol_d;
					source_q       <= source_d;
					dest_q         <= dest_d;
					sum_q          <= sum_d;
					high_q         <= high_d;
					rsum_q         <= rsum_d;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			payload_byte_q  <= head.rx_byte;
			payload_valid_q <= is_payload;
			packet_end_q    <= head.last_byte;
			verdict_q       <= verdict_d;
			protocol_out_q  <= protocol_d;
			source_out_q    <= source_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = payload_byte_q;
	assign payload_valid = payload_valid_q;
	assign packet_end    = packet_end_q;
	assign verdict       = verdict_q;
	assign protocol      = protocol_out_q;
	assign source_addr   = source_out_q;

endmodule
